/* rtl/indexed_insert_erase_array_assert.svh */
// Assertion macros shared by the indexed insert/erase array RTL.
// No dependencies; pulled in by `include where assertions are written.
`ifndef INDEXED_INSERT_ERASE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_ERASE_ARRAY_ASSERT_SVH

// Checked on every rising edge of clk, muted while rst is high.
`define IIEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define IIEA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/iiea_pkg.sv */
// Shared types and codes for the indexed insert/erase array.
// No dependencies; used by iiea_cell and indexed_insert_erase_array.
package iiea_pkg;

  localparam int POS_BITS   = 6;
  localparam int IO_WORD_W  = 32;
  localparam int CNT_OUT_W  = 6;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [POS_BITS-1:0]  position;
    logic [IO_WORD_W-1:0] word_in;
  } req_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IO_WORD_W-1:0] word_out;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 is_empty;
  } rsp_item_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic ins_en;
    logic era_en;
    logic rd_en;
  } cell_ctrl_t;

endpackage

/* rtl/iiea_cell.sv */
// One slot of the array row: shifts with its neighbors on insert/erase.
// Depends on iiea_pkg (cell_ctrl_t).
module iiea_cell #(
  parameter int WORD_BITS = 32,
  parameter int IDX_W     = 6,
  parameter int INDEX     = 0
) (
  input  logic                   clk,
  input  iiea_pkg::cell_ctrl_t   ctrl,
  input  logic [IDX_W-1:0]       pos,
  input  logic [WORD_BITS-1:0]   word,
  input  logic [WORD_BITS-1:0]   left_data,
  input  logic [WORD_BITS-1:0]   right_data,
  output logic [WORD_BITS-1:0]   data,
  output logic [WORD_BITS-1:0]   rd_data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic above;
  logic hit;

  assign above = MY_IDX > pos;
  assign hit   = MY_IDX == pos;

  always_ff @(posedge clk) begin
    if (ctrl.ins_en && above) begin
      data <= left_data;
    end else if (ctrl.ins_en && hit) begin
      data <= word;
    end else if (ctrl.era_en && (above || hit)) begin
      data <= right_data;
    end
  end

  // loaded on each read and held until the next one; zero except at the slot read
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= hit ? data : '0;
    end
  end

endmodule

/* rtl/indexed_insert_erase_array.sv */
// Top level of the indexed insert/erase array: sequencer, count, row of cells.
// Depends on iiea_pkg, iiea_cell and indexed_insert_erase_array_assert.svh.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-----------------------------------
//   req     | in  | req_valid/req_ready  | cmd, position, word_in
//   rsp     | out | rsp_valid/rsp_ready  | status, word_out, entry_count,
//           |     |                      | is_empty
//
// Each item passes through capture, row update (every cell shifts or loads
// together), and result assembly (OR of the per-cell read outputs).
// The sequencer handles one item at a time; req_ready is high in IDLE.
// A finished result sits in the rsp register; the next item is taken meanwhile
// and waits in its assembly cycle only if that register is still full.
// rst (synchronous) clears the sequencer, count and rsp_valid; slot contents
// are left as they are and are only ever read below the count.
`include "indexed_insert_erase_array_assert.svh"

module indexed_insert_erase_array #(
  parameter int CAPACITY  = 32,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  iiea_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output iiea_pkg::rsp_item_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  // wide enough for both the count and any requested position
  localparam int IDX_W = (CNT_W > iiea_pkg::POS_BITS) ? CNT_W : iiea_pkg::POS_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // captured item
  logic [1:0]           cmd;
  logic [IDX_W-1:0]     pos;
  logic [WORD_BITS-1:0] word;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [1:0]           status;
  logic [1:0]           status_next;

  iiea_pkg::cell_ctrl_t ctrl;
  logic [IDX_W-1:0]     count_ext;
  logic                 ins_ok;
  logic                 idx_ok;
  logic                 full;
  logic                 exec;
  logic                 rsp_load;

  logic [WORD_BITS-1:0] cell_data [CAPACITY];
  logic [WORD_BITS-1:0] cell_rd   [CAPACITY];
  logic [WORD_BITS-1:0] rd_word;

  assign req_ready = (state == S_IDLE);
  assign exec      = (state == S_EXEC);
  assign rsp_load  = (state == S_RESP) && (!rsp_valid || rsp_ready);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_RESP;
      S_RESP: if (rsp_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd  <= req.cmd;
      pos  <= IDX_W'(req.position);
      word <= WORD_BITS'(req.word_in);
    end
  end

  // ---------------------------------------------------- range checks, count
  assign count_ext = IDX_W'(count);
  assign ins_ok    = pos <= count_ext;   // insert may append at the end
  assign idx_ok    = pos <  count_ext;
  assign full      = count == CAP_CNT;

  assign ctrl.ins_en = exec && (cmd == iiea_pkg::CMD_INSERT) && ins_ok && !full;
  assign ctrl.era_en = exec && (cmd == iiea_pkg::CMD_ERASE) && idx_ok;
  assign ctrl.rd_en  = exec && (cmd == iiea_pkg::CMD_READ) && idx_ok;

  always_comb begin
    count_next  = count;
    status_next = iiea_pkg::ST_OK;
    case (cmd)
      iiea_pkg::CMD_INSERT: begin
        // range error wins over full
        if (!ins_ok) begin
          status_next = iiea_pkg::ST_RANGE;
        end else if (full) begin
          status_next = iiea_pkg::ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      iiea_pkg::CMD_ERASE: begin
        if (!idx_ok) begin
          status_next = iiea_pkg::ST_RANGE;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      iiea_pkg::CMD_READ: begin
        if (!idx_ok) status_next = iiea_pkg::ST_RANGE;
      end
      iiea_pkg::CMD_CLEAR: count_next = '0;   // slots keep their contents
      default: status_next = iiea_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) status <= status_next;
  end

  // ------------------------------------------------------------- cell row
  // Cell i takes from i-1 on insert and from i+1 on erase; the end cells
  // feed back their own data where no neighbor exists (unused at cell 0; on erase the last cell keeps its word).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    iiea_cell #(
      .WORD_BITS(WORD_BITS),
      .IDX_W    (IDX_W),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (pos),
      .word      (word),
      .left_data ((i == 0) ? cell_data[i] : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data((i == CAPACITY - 1) ? cell_data[i]
                                      : cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data      (cell_data[i]),
      .rd_data   (cell_rd[i])
    );
  end

  // at most one cell drives a nonzero read word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // --------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // cell read words hold the last good read; only a good read passes them on
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status      <= status;
      rsp.word_out    <= ((cmd == iiea_pkg::CMD_READ) && (status == iiea_pkg::ST_OK))
                         ? iiea_pkg::IO_WORD_W'(rd_word) : '0;
      rsp.entry_count <= iiea_pkg::CNT_OUT_W'(count);
      rsp.is_empty    <= (count == '0);
    end
  end

  // ---------------------------------------------------------------- checks
  `IIEA_ASSERT(a_count_bound, count <= CAP_CNT, "count above capacity")
  `IIEA_ASSERT(a_exec_to_resp, exec |=> (state == S_RESP), "row update not followed by result")
  `IIEA_ASSERT(a_rsp_source, $rose(rsp_valid) |-> $past(state == S_RESP), "result without item")
  `IIEA_ASSERT(a_ins_count, ctrl.ins_en |=> (count == $past(count) + CNT_W'(1)), "insert count")
  `IIEA_ASSERT(a_era_count, ctrl.era_en |=> (count == $past(count) - CNT_W'(1)), "erase count")
  `IIEA_ASSERT_ALWAYS(a_rst_idle, rst |=> (state == S_IDLE) && !rsp_valid, "reset state")

endmodule
